>>> rtl/lssf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-sensor steering filter: shared package
// Field widths, the result record and the middle-to-angle mapping.
// ----------------------------------------------------------------------------
package lssf_pkg;

  // Widths of the fixed fields.
  localparam int IN_W    = 16;
  localparam int MID_W   = 4;
  localparam int LIMIT_W = 4;
  localparam int ANGLE_W = 8;

  // Jump limit after reset.
  localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RST = 4'd5;

  typedef logic [MID_W-1:0]          middle_t;
  typedef logic [LIMIT_W-1:0]        limit_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // One result as it leaves the block.
  typedef struct packed {
    angle_t  angle;
    middle_t middle;
    logic    rejected;
    logic    no_line;
  } result_t;

  // Servo angle for a middle: -((m - 5) * 70 / 9 - 35), quotient truncated
  // towards zero. Sixteen middles, so a constant table does the job.
  function automatic angle_t angle_of(input middle_t m);
    angle_t a;
    unique case (m)
      4'd0:  a = 8'sd73;
      4'd1:  a = 8'sd66;
      4'd2:  a = 8'sd58;
      4'd3:  a = 8'sd50;
      4'd4:  a = 8'sd42;
      4'd5:  a = 8'sd35;
      4'd6:  a = 8'sd28;
      4'd7:  a = 8'sd20;
      4'd8:  a = 8'sd12;
      4'd9:  a = 8'sd4;
      4'd10: a = -8'sd3;
      4'd11: a = -8'sd11;
      4'd12: a = -8'sd19;
      4'd13: a = -8'sd27;
      4'd14: a = -8'sd35;
      4'd15: a = -8'sd42;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/lssf_run_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Longest zero-run search
// Finds the longest run of zero bits in the sensor word (lowest start wins on
// a tie) and returns the run start plus half its length as the candidate.
// ----------------------------------------------------------------------------
module lssf_run_find #(
  parameter int SENSOR_COUNT = 16
) (
  input  logic [lssf_pkg::IN_W-1:0] sensor_bits,
  output logic                      found,
  output lssf_pkg::middle_t         middle
);

  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int LEN_W = $clog2(SENSOR_COUNT + 1);
  localparam int NPAD  = 1 << IDX_W;
  localparam int SUM_W = LEN_W + 1;

  logic [SENSOR_COUNT-1:0] zero_bits;
  logic [LEN_W-1:0]        run_len [NPAD];
  logic [LEN_W-1:0]        lvl_len [IDX_W+1][NPAD];
  logic [IDX_W-1:0]        lvl_idx [IDX_W+1][NPAD];
  logic [LEN_W-1:0]        best_len;
  logic [IDX_W-1:0]        best_idx;
  logic [SUM_W-1:0]        mid_sum;

  // Sensors beyond the input word read as line seen.
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_zero
    if (g < lssf_pkg::IN_W) begin : g_in
      assign zero_bits[g] = ~sensor_bits[g];
    end else begin : g_pad
      assign zero_bits[g] = 1'b1;
    end
  end

  // Zero-run length starting at each position: distance to the nearest one
  // bit at or above it, a priority encoder per position.
  always_comb begin
    for (int i = 0; i < NPAD; i++) begin
      run_len[i] = '0;
      if (i < SENSOR_COUNT) begin
        run_len[i] = LEN_W'(SENSOR_COUNT - i);
        for (int j = SENSOR_COUNT - 1; j >= i; j--) begin
          if (!zero_bits[j]) begin
            run_len[i] = LEN_W'(j - i);
          end
        end
      end
    end
  end

  // Maximum over the positions by a compare tree. The right-hand node wins
  // only when strictly longer, so the lowest start is kept on a tie. A
  // position inside a run is always shorter than the run's own start.
  always_comb begin
    for (int l = 0; l <= IDX_W; l++) begin
      for (int k = 0; k < NPAD; k++) begin
        lvl_len[l][k] = '0;
        lvl_idx[l][k] = '0;
      end
    end
    for (int k = 0; k < NPAD; k++) begin
      lvl_len[0][k] = run_len[k];
      lvl_idx[0][k] = IDX_W'(k);
    end
    for (int l = 0; l < IDX_W; l++) begin
      for (int k = 0; k < (NPAD >> (l + 1)); k++) begin
        if (lvl_len[l][2*k+1] > lvl_len[l][2*k]) begin
          lvl_len[l+1][k] = lvl_len[l][2*k+1];
          lvl_idx[l+1][k] = lvl_idx[l][2*k+1];
        end else begin
          lvl_len[l+1][k] = lvl_len[l][2*k];
          lvl_idx[l+1][k] = lvl_idx[l][2*k];
        end
      end
    end
  end

  assign best_len = lvl_len[IDX_W][0];
  assign best_idx = lvl_idx[IDX_W][0];

  // Candidate middle, kept modulo sixteen.
  assign mid_sum = SUM_W'(best_idx) + SUM_W'(best_len >> 1);
  assign middle  = mid_sum[lssf_pkg::MID_W-1:0];
  assign found   = (best_len != '0);

endmodule

>>> rtl/lssf_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Middle tracker
// Holds the last accepted middle, applies the jump limit to each candidate
// and forms the result for the output register.
// ----------------------------------------------------------------------------
module lssf_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                found,
  input  lssf_pkg::middle_t   cand,
  input  lssf_pkg::limit_t    jump_limit,
  output logic                first_pending,
  output lssf_pkg::result_t   res_nxt
);

  lssf_pkg::middle_t last_middle_r, last_middle_nxt;
  logic              first_pending_r, first_pending_nxt;
  lssf_pkg::middle_t mid_gap;
  logic              rejected;

  // Distance between the candidate and the last accepted middle.
  assign mid_gap = (cand > last_middle_r) ? (cand - last_middle_r) : (last_middle_r - cand);

  // Acceptance decision.
  always_comb begin
    last_middle_nxt   = last_middle_r;
    first_pending_nxt = first_pending_r;
    rejected          = 1'b0;
    priority if (!found) begin
      // No line seen: everything held.
    end else if (first_pending_r) begin
      last_middle_nxt   = cand;
      first_pending_nxt = 1'b0;
    end else if (mid_gap < jump_limit) begin
      last_middle_nxt = cand;
    end else begin
      rejected = 1'b1;
    end
  end

  // The result reports the middle after this transaction.
  always_comb begin
    res_nxt.angle    = lssf_pkg::angle_of(last_middle_nxt);
    res_nxt.middle   = last_middle_nxt;
    res_nxt.rejected = rejected;
    res_nxt.no_line  = ~found;
  end

  // Tracking state, updated when a transaction moves to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_middle_r   <= '0;
      first_pending_r <= 1'b1;
    end else if (advance) begin
      last_middle_r   <= last_middle_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

  assign first_pending = first_pending_r;

endmodule

>>> rtl/line_sensor_steering_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-sensor steering filter
// Turns a line-sensor word into a filtered line middle and a servo angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one sensor word per transaction;
//   a zero bit marks a sensor that sees the line. Output channel
//   out_valid/out_ready returns one result per input: steering angle, line
//   middle, a jump-rejected flag and a no-line flag.
//   cfg_we/cfg_wdata writes the jump limit; write it only while idle.
//   The word is registered on acceptance; the run search, jump filter and
//   angle table sit between that register and the result register. One
//   transaction is taken every cycle while the output side takes results,
//   as the run search covers the whole sensor word in one pass.
//   If the receiver stalls, the result register holds its result and one
//   further word waits in the input register; in_ready then drops.
//   Reset empties both registers, sets the jump limit to five, the last
//   middle to zero and makes the next measurement with a line accepted
//   unconditionally.
// ----------------------------------------------------------------------------
module line_sensor_steering_filter #(
  parameter int SENSOR_COUNT = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lssf_pkg::IN_W-1:0]            in_sensor_bits,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lssf_pkg::ANGLE_W-1:0]  out_steering_angle,
  output logic [lssf_pkg::MID_W-1:0]           out_line_middle,
  output logic                                 out_jump_rejected,
  output logic                                 out_no_line,
  input  logic                                 cfg_we,
  input  logic [lssf_pkg::LIMIT_W-1:0]         cfg_wdata
);

  logic                        in_valid_r;
  logic [lssf_pkg::IN_W-1:0]   bits_r;
  logic                        out_valid_r;
  lssf_pkg::result_t           res_r;
  lssf_pkg::result_t           res_nxt;
  lssf_pkg::limit_t            jump_limit_r;
  logic                        advance;
  logic                        found;
  lssf_pkg::middle_t           cand;
  logic                        first_pending;

  // Pipeline flow: the input register moves on when the result register is
  // free or being emptied.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_limit_r <= lssf_pkg::JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      jump_limit_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bits_r <= in_sensor_bits;
    end
  end

  // Run search and jump filter.
  lssf_run_find #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_run_find (
    .sensor_bits (bits_r),
    .found       (found),
    .middle      (cand)
  );

  lssf_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .found         (found),
    .cand          (cand),
    .jump_limit    (jump_limit_r),
    .first_pending (first_pending),
    .res_nxt       (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_steering_angle = res_r.angle;
  assign out_line_middle    = res_r.middle;
  assign out_jump_rejected  = res_r.rejected;
  assign out_no_line        = res_r.no_line;

  // A result is never both a rejected jump and a missing line.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.rejected && res_r.no_line))
    else $error("jump_rejected and no_line both set");

  // The angle always belongs to the middle reported with it.
  a_angle_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.angle == lssf_pkg::angle_of(res_r.middle)))
    else $error("steering angle does not match line middle");

  // No jump can be rejected before the first measurement is taken.
  a_first_no_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && first_pending) |-> !res_nxt.rejected)
    else $error("jump rejected before first measurement");

  // Input back-pressure only when both registers are full and stalled.
  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low with room in the pipeline");

endmodule

>>> test/tb_line_sensor_steering_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line-sensor steering filter: self-checking testbench
// Sensor words go in through the input channel while a predictor in the bench
// tracks the jump filter and works out each result. The results that come out
// are compared field by field, under several jump limits and idling patterns.
// ----------------------------------------------------------------------------
module tb_line_sensor_steering_filter;

  localparam int CLK_PERIOD = 12;
  localparam int SENSORS    = 16;
  localparam int WORDS_PER_PHASE = 400;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [lssf_pkg::IN_W-1:0] in_sensor_bits = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  lssf_pkg::angle_t          out_steering_angle;
  lssf_pkg::middle_t         out_line_middle;
  logic                      out_jump_rejected;
  logic                      out_no_line;
  logic                      cfg_we = 1'b0;
  lssf_pkg::limit_t          cfg_wdata = '0;

  // Predicted filter state and the results still awaited.
  lssf_pkg::limit_t  model_limit;
  lssf_pkg::middle_t model_middle;
  logic              model_first;
  lssf_pkg::result_t steer_q[$];

  int words_sent  = 0;
  int steers_seen = 0;
  int fail_count  = 0;

  // Idling controls; the hold request is handed to the receiver by a tag.
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_len  = 0;
  int hold_tag  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  line_sensor_steering_filter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sensor_bits     (in_sensor_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_steering_angle (out_steering_angle),
    .out_line_middle    (out_line_middle),
    .out_jump_rejected  (out_jump_rejected),
    .out_no_line        (out_no_line),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Finds the longest zero run (lowest start on a tie), filters its middle
  // against the last accepted one and maps the held middle to a servo angle.
  function automatic lssf_pkg::result_t predict_steer(input logic [lssf_pkg::IN_W-1:0] bits);
    lssf_pkg::result_t r;
    lssf_pkg::middle_t cand;
    int best_len, best_start, run_len, i, mid_gap, d, q;
    best_len = 0;
    best_start = 0;
    i = 0;
    while (i < SENSORS) begin
      if (!bits[i]) begin
        run_len = 1;
        while (i + run_len < SENSORS && !bits[i + run_len]) run_len++;
        if (run_len > best_len) begin
          best_len = run_len;
          best_start = i;
        end
        i += run_len;
      end else begin
        i++;
      end
    end
    r.rejected = 1'b0;
    r.no_line = 1'b0;
    if (best_len == 0) begin
      r.no_line = 1'b1;
    end else begin
      cand = lssf_pkg::middle_t'(best_start + best_len / 2);
      mid_gap = (cand > model_middle) ? int'(cand) - int'(model_middle)
                                      : int'(model_middle) - int'(cand);
      if (model_first) begin
        model_first = 1'b0;
        model_middle = cand;
      end else if (mid_gap < int'(model_limit)) begin
        model_middle = cand;
      end else begin
        r.rejected = 1'b1;
      end
    end
    d = (int'(model_middle) - 5) * 70;
    q = (d < 0) ? -((-d) / 9) : d / 9;
    r.angle = lssf_pkg::angle_t'(35 - q);
    r.middle = model_middle;
    return r;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // Scoreboard: checks each result transaction, then records the prediction
  // for any sensor word and any jump limit taken at this edge.
  always @(posedge clk) begin : steer_check
    lssf_pkg::result_t want;
    if (!rst_n) begin
      model_limit = lssf_pkg::JUMP_LIMIT_RST;
      model_middle = '0;
      model_first = 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        steers_seen++;
        if (steer_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no expectation: expected none, got middle %0d",
                   $time, out_line_middle);
        end else begin
          want = steer_q.pop_front();
          check_field("steering_angle", want.angle, out_steering_angle);
          check_field("line_middle", want.middle, out_line_middle);
          check_field("jump_rejected", want.rejected, out_jump_rejected);
          check_field("no_line", want.no_line, out_no_line);
        end
      end
      if (in_valid && in_ready) steer_q.push_back(predict_steer(in_sensor_bits));
      if (cfg_we) model_limit = cfg_wdata;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one sensor word after a random gap and waits for its transaction.
  task automatic send_word(input logic [lssf_pkg::IN_W-1:0] bits);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_bits <= bits;
    words_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering words and waits until every result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (steers_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input lssf_pkg::limit_t value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a plausible line near the current middle, sometimes with a stray
  // sensor; the rest is random noise and words with no line at all.
  function automatic logic [lssf_pkg::IN_W-1:0] line_word();
    logic [lssf_pkg::IN_W-1:0] w;
    int sel, width, lo;
    sel = $urandom_range(99);
    if (sel < 8) return '1;
    if (sel < 25) return lssf_pkg::IN_W'($urandom_range(0, 65535));
    width = ($urandom_range(9) == 0) ? $urandom_range(7, SENSORS) : $urandom_range(1, 6);
    lo = int'(model_middle) + $urandom_range(0, 10) - 5 - width / 2;
    if (lo < 0) lo = 0;
    if (lo > SENSORS - width) lo = SENSORS - width;
    w = '1;
    for (int k = 0; k < width; k++) w[lo + k] = 1'b0;
    if ($urandom_range(3) == 0) w[$urandom_range(SENSORS - 1)] = 1'b0;
    return w;
  endfunction

  // Field extremes, ties, exact-limit distances and the no-line hold,
  // starting with no line before the first measurement.
  task automatic test_directed();
    logic [lssf_pkg::IN_W-1:0] words[] = '{
      16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hBFFF, 16'h87FF, 16'hFF1F,
      16'hF0F0, 16'hFC3F, 16'hFE7F, 16'h8001, 16'hFF00, 16'h00FF, 16'h0FF0,
      16'hAAAA, 16'h5555, 16'hFFFE, 16'hFFFC, 16'hFFF8, 16'hFFFF};
    foreach (words[k]) send_word(words[k]);
    wait_drained();
  endtask

  // Jump limit at both extremes and in between; zero rejects every jump.
  task automatic test_jump_limits();
    lssf_pkg::limit_t limits[] = '{4'd0, 4'd15, 4'd1, 4'd5};
    foreach (limits[k]) begin
      write_limit(limits[k]);
      repeat (40) send_word(line_word());
    end
    write_limit(lssf_pkg::limit_t'($urandom_range(2, 14)));
    repeat (40) send_word(line_word());
  endtask

  // Random words under each idling pattern, with a full pause half-way.
  task automatic test_random_phases();
    int gaps[]   = '{0, 60, 0, 7};
    int stalls[] = '{0, 0, 60, 7};
    foreach (gaps[p]) begin
      write_limit(lssf_pkg::limit_t'($urandom_range(0, 15)));
      gap_pct = gaps[p];
      stall_pct = stalls[p];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE / 2) wait_drained();
        send_word(line_word());
      end
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // block fills up and drops in_ready.
  task automatic test_backpressure();
    wait_drained();
    hold_len = 60;
    hold_tag++;
    repeat (30) send_word(line_word());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_jump_limits();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (steer_q.size() != 0) begin
      fail_count++;
      $display("%0t: results left over: expected 0, got %0d", $time, steer_q.size());
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
